@@ rtl/multi_tap_delay_reverb_defines.svh @@
// Assertion helpers for the reverb block.
`ifndef MULTI_TAP_DELAY_REVERB_DEFINES_SVH
`define MULTI_TAP_DELAY_REVERB_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define MTDR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define MTDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/mtdr_pkg.sv @@
`default_nettype none

package mtdr_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TAPS_IN_USE = 3'd0;
  localparam logic [2:0] CFG_DELAY_ONE   = 3'd1;
  localparam logic [2:0] CFG_GAIN_ONE    = 3'd4;

  localparam int DELAY_W = 14;
  localparam int GAIN_W  = 16;
  localparam int SAMPLE_W = 16;
  localparam int PROD_W  = SAMPLE_W + GAIN_W + 1;
  localparam int ACC_W   = 36;
  localparam int FRAC_W  = 15;
  localparam int WHOLE_W = ACC_W - FRAC_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP,
    ST_WRITE,
    ST_FLUSH,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/multi_tap_delay_reverb.sv @@
// Multi-tap delay reverb, one sample per item, single-port history memory.
// Each item passes through an accept step, a history read step per tap slot, a write-back
// step, a product flush step and a result step; the single memory port sets this order.
// out_tvalid rises when the output register is free; a stalled result holds the
// sequencer in its result state.
// Synchronous active-low reset clears control state and loads the register defaults;
// the history memory is not cleared, the seen_r count guards every read.
`default_nettype none
`include "multi_tap_delay_reverb_defines.svh"

module multi_tap_delay_reverb #(
  parameter int HISTORY_DEPTH = 16384,
  parameter int TAP_COUNT     = 3
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] sample_in
  input  wire logic        in_tuser,   // [0] restart
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] sample_out
  output logic             out_tuser,  // [0] clipped
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int SW = $clog2(HISTORY_DEPTH + 1);
  // wide enough for write position, delay and count, plus a sign bit
  localparam int DW = ((AW > mtdr_pkg::DELAY_W) ? AW : mtdr_pkg::DELAY_W) + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0]                    taps_r;
  logic [mtdr_pkg::DELAY_W-1:0]  delay_r [TAP_COUNT];
  logic [mtdr_pkg::GAIN_W-1:0]   gain_r  [TAP_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r <= 2'd0;
      for (int k = 0; k < TAP_COUNT; k++) begin
        delay_r[k] <= mtdr_pkg::DELAY_W'(1);
        gain_r[k]  <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == mtdr_pkg::CFG_TAPS_IN_USE) begin
        taps_r <= cfg_wdata[1:0];
      end
      for (int k = 0; k < TAP_COUNT; k++) begin
        if (cfg_index == mtdr_pkg::CFG_DELAY_ONE + 3'(k)) begin
          delay_r[k] <= cfg_wdata[mtdr_pkg::DELAY_W-1:0];
        end
        if (cfg_index == mtdr_pkg::CFG_GAIN_ONE + 3'(k)) begin
          gain_r[k] <= cfg_wdata;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and item registers
  // ---------------------------------------------------------------------------
  mtdr_pkg::state_t state_r, state_nxt;
  logic [1:0]       k_r, k_nxt;          // tap slot being read
  logic [1:0]       rd_k_r;              // tap slot of the data now on the read port
  logic             rd_vld_r;            // read data belongs to a contributing tap
  logic             prod_vld_r;          // product register holds a term to add
  logic [AW-1:0]    wp_r;                // slot for the current sample
  logic [SW-1:0]    seen_r;              // samples of the track before this one
  logic signed [mtdr_pkg::SAMPLE_W-1:0] sample_r;
  logic signed [mtdr_pkg::PROD_W-1:0]   prod_r;
  logic signed [mtdr_pkg::ACC_W-1:0]    acc_r;

  logic             out_valid_r;
  logic [15:0]      out_data_r;
  logic             out_clip_r;

  logic             accept;
  logic             rd_en;
  logic             mem_we;
  logic             out_load;
  logic             tap_ok;
  logic [1:0]       active;
  logic [mtdr_pkg::DELAY_W-1:0] delay_sel;
  logic [mtdr_pkg::GAIN_W-1:0]  gain_sel;
  logic signed [DW-1:0]         slot_diff;
  logic [AW-1:0]                mem_addr;

  assign active = (taps_r > 2'(TAP_COUNT)) ? 2'(TAP_COUNT) : taps_r;
  assign accept = in_tvalid && in_tready;

  // Pick the delay of the slot being read and the gain of the data returned.
  always_comb begin
    delay_sel = '0;
    gain_sel  = '0;
    for (int k = 0; k < TAP_COUNT; k++) begin
      if (k_r == 2'(k)) begin
        delay_sel = delay_r[k];
      end
      if (rd_k_r == 2'(k)) begin
        gain_sel = gain_r[k];
      end
    end
  end

  // A tap counts only when active, with a non-zero delay that stays inside the track.
  assign tap_ok = (k_r < active) && (delay_sel != '0) && (DW'(delay_sel) <= DW'(seen_r));

  // Slot = write position minus delay, wrapped once into the memory depth.
  always_comb begin
    slot_diff = $signed(DW'(wp_r)) - $signed(DW'(delay_sel));
    if (slot_diff[DW-1]) begin
      slot_diff = slot_diff + $signed(DW'(HISTORY_DEPTH));
    end
  end

  assign mem_addr = mem_we ? wp_r : slot_diff[AW-1:0];

  // Next state and handshake outputs.
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    in_tready = 1'b0;
    rd_en     = 1'b0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      mtdr_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        k_nxt     = 2'd0;
        if (in_tvalid) begin
          state_nxt = mtdr_pkg::ST_TAP;
        end
      end
      mtdr_pkg::ST_TAP: begin
        rd_en = tap_ok;
        if (k_r == 2'(TAP_COUNT - 1)) begin
          state_nxt = mtdr_pkg::ST_WRITE;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      mtdr_pkg::ST_WRITE: begin
        // all reads are out: store the dry sample
        mem_we    = 1'b1;
        state_nxt = mtdr_pkg::ST_FLUSH;
      end
      mtdr_pkg::ST_FLUSH: begin
        state_nxt = mtdr_pkg::ST_DONE;
      end
      mtdr_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = mtdr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mtdr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mtdr_pkg::ST_IDLE;
      k_r        <= 2'd0;
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
      wp_r       <= '0;
      seen_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      k_r        <= k_nxt;
      rd_vld_r   <= rd_en;
      prod_vld_r <= rd_vld_r;
      if (accept && in_tuser) begin
        // new track: forget the history before this sample
        seen_r <= '0;
      end else if (mem_we) begin
        if (seen_r < SW'(HISTORY_DEPTH)) begin
          seen_r <= seen_r + SW'(1);
        end
        wp_r <= (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // History memory, one port, registered read
  // ---------------------------------------------------------------------------
  logic [mtdr_pkg::SAMPLE_W-1:0] mem [HISTORY_DEPTH];
  logic signed [mtdr_pkg::SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= sample_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath: multiply, accumulate, truncate, saturate
  // ---------------------------------------------------------------------------
  logic signed [mtdr_pkg::WHOLE_W-1:0] whole;
  logic                                trunc_adj;
  logic [15:0]                         sat_data;
  logic                                sat_clip;

  always_ff @(posedge clk) begin
    rd_k_r <= k_r;
    if (accept) begin
      sample_r <= $signed(in_tdata);
      // dry sample in Q.15
      acc_r <= {{(mtdr_pkg::ACC_W - mtdr_pkg::SAMPLE_W - mtdr_pkg::FRAC_W){in_tdata[15]}},
                in_tdata, {mtdr_pkg::FRAC_W{1'b0}}};
    end else if (prod_vld_r) begin
      acc_r <= acc_r + mtdr_pkg::ACC_W'(prod_r);
    end
    if (rd_vld_r) begin
      prod_r <= rd_data_r * $signed({1'b0, gain_sel});
    end
  end

  // Truncate toward zero: bump negative values with a non-zero fraction.
  assign trunc_adj = acc_r[mtdr_pkg::ACC_W-1] && (acc_r[mtdr_pkg::FRAC_W-1:0] != '0);
  assign whole = $signed(acc_r[mtdr_pkg::ACC_W-1:mtdr_pkg::FRAC_W])
               + $signed({{(mtdr_pkg::WHOLE_W-1){1'b0}}, trunc_adj});

  always_comb begin
    sat_clip = 1'b0;
    sat_data = whole[15:0];
    if (whole > $signed(mtdr_pkg::WHOLE_W'(32767))) begin
      sat_data = 16'h7FFF;
      sat_clip = 1'b1;
    end else if (whole < -$signed(mtdr_pkg::WHOLE_W'(32768))) begin
      sat_data = 16'h8000;
      sat_clip = 1'b1;
    end
  end

  // Output register parts the result side from the sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_data_r <= sat_data;
      out_clip_r <= sat_clip;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_clip_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `MTDR_ASSERT_NOW(a_port_excl, clk, rst_n, mem_we, !rd_en)
  `MTDR_ASSERT_NEXT(a_read_to_prod, clk, rst_n, rd_vld_r, prod_vld_r)
  `MTDR_ASSERT_NEXT(a_load_shows, clk, rst_n, out_load, out_valid_r && in_tready)

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
module tb_top;

  // Block configuration under test, the settling time after the last result and the run's limit.
  localparam int DEPTH         = 16384;
  localparam int TAPS          = 3;
  localparam int SETTLE_CYCLES = TAPS + 10;
  localparam int CYCLE_LIMIT   = 300000;

  // Register indexes that the package does not name: the taps sit in order after the first.
  localparam logic [2:0] CFG_DELAY_TWO   = mtdr_pkg::CFG_DELAY_ONE + 3'd1;
  localparam logic [2:0] CFG_DELAY_THREE = mtdr_pkg::CFG_DELAY_ONE + 3'd2;
  localparam logic [2:0] CFG_GAIN_TWO    = mtdr_pkg::CFG_GAIN_ONE + 3'd1;
  localparam logic [2:0] CFG_GAIN_THREE  = mtdr_pkg::CFG_GAIN_ONE + 3'd2;

  // Idling profiles: which side, if any, holds off at random.
  localparam int IDLE_NONE     = 0;
  localparam int IDLE_SENDER   = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH     = 3;

  typedef struct packed {
    logic               restart;
    logic signed [15:0] sample;
  } dry_item_t;

  typedef struct packed {
    logic        clipped;
    logic [15:0] sample;
  } wet_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // [15:0] sample_in
  logic        in_tuser   = 1'b0; // [0] restart
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [15:0] sample_out
  logic        out_tuser;         // [0] clipped
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_index  = '0;
  logic [15:0] cfg_wdata  = '0;

  multi_tap_delay_reverb #(
    .HISTORY_DEPTH(DEPTH),
    .TAP_COUNT    (TAPS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: its own copy of the registers and of the sample history.
  logic [1:0]         taps_cfg = 2'd0;
  logic [13:0]        delay_cfg [TAPS] = '{default: 14'd1};
  logic [15:0]        gain_cfg  [TAPS] = '{default: 16'd0};
  logic signed [15:0] history   [DEPTH];
  int                 wr_pos    = 0;
  int                 track_len = 0;

  dry_item_t   dry_pending [$];
  wet_result_t wet_expected [$];
  dry_item_t   presented;
  int          owed_results = 0;
  int          gap_pct      = 0;
  int          stall_pct    = 0;
  int          errors       = 0;
  int          cycle_count  = 0;

  // Work out the wet sample for one accepted item and advance the history.
  task automatic mix_wet_sample(input dry_item_t item);
    longint      acc;
    longint      whole;
    int          slot;
    wet_result_t res;
    if (item.restart)
      track_len = 0;
    acc = longint'($signed(item.sample)) * 32768;
    for (int k = 0; k < TAPS; k++) begin
      // Skip inactive taps, zero delays and delays that reach before the track began.
      if (k < taps_cfg && delay_cfg[k] != 0 && int'(delay_cfg[k]) <= track_len) begin
        slot = (wr_pos + DEPTH - int'(delay_cfg[k])) % DEPTH;
        acc += longint'(history[slot]) * longint'({1'b0, gain_cfg[k]});
      end
    end
    // Truncate toward zero once, then saturate.
    whole = acc / 32768;
    res.clipped = 1'b0;
    if (whole > 32767) begin
      whole = 32767;
      res.clipped = 1'b1;
    end else if (whole < -32768) begin
      whole = -32768;
      res.clipped = 1'b1;
    end
    res.sample = whole[15:0];
    history[wr_pos] = item.sample;
    wr_pos = (wr_pos + 1) % DEPTH;
    if (track_len < DEPTH)
      track_len++;
    wet_expected.push_back(res);
  endtask

  // Driver: present pending items, hold each one until it is taken, gap at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        mix_wet_sample(presented);
      if (!in_tvalid || in_tready) begin
        if (dry_pending.size() != 0 && $urandom_range(99) >= gap_pct) begin
          presented = dry_pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= presented.sample;
          in_tuser  <= presented.restart;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest expectation, stall at random.
  always @(posedge clk) begin : wet_monitor
    wet_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (wet_expected.size() == 0) begin
          $display("%0t: unexpected result sample_out %0d clipped %0b", $time,
                   $signed(out_tdata), out_tuser);
          errors++;
        end else begin
          want = wet_expected.pop_front();
          owed_results--;
          if (out_tdata !== want.sample) begin
            $display("%0t: sample_out expected %0d actual %0d", $time,
                     $signed(want.sample), $signed(out_tdata));
            errors++;
          end
          if (out_tuser !== want.clipped) begin
            $display("%0t: clipped expected %0b actual %0b", $time, want.clipped, out_tuser);
            errors++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: a hung block ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic queue_dry(input logic signed [15:0] sample, input logic restart);
    dry_item_t item;
    item.sample  = sample;
    item.restart = restart;
    dry_pending.push_back(item);
    owed_results++;
  endtask

  // Hold until every result is in, then let the pipeline empty out.
  task automatic wait_drained();
    while (owed_results != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == mtdr_pkg::CFG_TAPS_IN_USE)
      taps_cfg = value[1:0];
    else if (idx < mtdr_pkg::CFG_GAIN_ONE)
      delay_cfg[idx - mtdr_pkg::CFG_DELAY_ONE] = value[13:0];
    else
      gain_cfg[idx - mtdr_pkg::CFG_GAIN_ONE] = value;
  endtask

  // Write every register, one per cycle, then drop the write enable.
  task automatic load_setting(input logic [1:0] taps,
                              input logic [13:0] d1, input logic [13:0] d2,
                              input logic [13:0] d3,
                              input logic [15:0] g1, input logic [15:0] g2,
                              input logic [15:0] g3);
    write_reg(mtdr_pkg::CFG_TAPS_IN_USE, {14'd0, taps});
    write_reg(mtdr_pkg::CFG_DELAY_ONE,   {2'd0, d1});
    write_reg(CFG_DELAY_TWO,   {2'd0, d2});
    write_reg(CFG_DELAY_THREE, {2'd0, d3});
    write_reg(mtdr_pkg::CFG_GAIN_ONE,    g1);
    write_reg(CFG_GAIN_TWO,    g2);
    write_reg(CFG_GAIN_THREE,  g3);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int mode);
    gap_pct   = (mode == IDLE_SENDER)   ? 49 : (mode == IDLE_BOTH) ? 21 : 0;
    stall_pct = (mode == IDLE_RECEIVER) ? 49 : (mode == IDLE_BOTH) ? 21 : 0;
  endtask

  // Mostly full-range noise, with quiet passages and rail values mixed in.
  function automatic logic signed [15:0] random_sample();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0)
      return 16'sh7fff;
    if (pick == 1)
      return 16'sh8000;
    if (pick < 4)
      return 16'(int'($urandom_range(4000)) - 2000);
    return 16'($urandom);
  endfunction

  // Short delays dominate so that taps land inside the tracks; keep a few at the edges.
  function automatic logic [13:0] random_delay();
    int pick;
    pick = $urandom_range(15);
    if (pick == 0)
      return 14'd0;
    if (pick == 1)
      return 14'h3fff;
    if (pick < 4)
      return 14'($urandom_range(300, 1));
    return 14'($urandom_range(40, 1));
  endfunction

  function automatic logic [15:0] random_gain();
    int pick;
    pick = $urandom_range(15);
    if (pick == 0)
      return 16'd0;
    if (pick == 1)
      return 16'd32768;
    if (pick == 2)
      return 16'hffff;
    if (pick == 3)
      return 16'($urandom_range(65535));
    return 16'($urandom_range(32768));
  endfunction

  // Tracks run long; a restart now and then cuts the history short.
  task automatic queue_track(input int count, input bit fresh_start);
    for (int i = 0; i < count; i++)
      queue_dry(random_sample(), (i == 0 && fresh_start) || $urandom_range(79) == 0);
  endtask

  initial begin : stimulus
    logic [1:0] taps;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Registers at their reset values: dry passthrough of the rail samples, zero and minus one.
    set_idling(IDLE_NONE);
    queue_dry(16'sh8000, 1'b1);
    queue_dry(16'sh7fff, 1'b0);
    queue_dry(16'sh0000, 1'b0);
    queue_dry(16'shffff, 1'b0);
    wait_drained();

    // Unity taps: nothing added at track start, then clipping at both rails.
    load_setting(2'd3, 14'd1, 14'd2, 14'd3, 16'd32768, 16'd32768, 16'd32768);
    queue_dry(16'sh7fff, 1'b1);
    queue_dry(16'sh7fff, 1'b0);
    queue_dry(16'sh7fff, 1'b0);
    queue_dry(16'sh7fff, 1'b0);
    queue_dry(16'sh8000, 1'b1);
    queue_dry(16'sh8000, 1'b0);
    queue_dry(16'sh8000, 1'b0);
    queue_dry(16'sd100, 1'b0);
    queue_dry(-16'sd5, 1'b0);
    wait_drained();

    // Gain above unity, a zero delay and the longest delay; odd gains test truncation.
    load_setting(2'd3, 14'd1, 14'd0, 14'h3fff, 16'hffff, 16'd12345, 16'd1);
    queue_dry(16'sd1234, 1'b1);
    queue_dry(-16'sd3, 1'b0);
    queue_dry(16'sd5, 1'b0);
    queue_dry(-16'sd7, 1'b0);
    queue_dry(16'sh7fff, 1'b0);
    queue_dry(16'sh8000, 1'b0);
    wait_drained();

    // Two taps in use: the third must stay silent.
    load_setting(2'd2, 14'd2, 14'd1, 14'd1, 16'd32768, 16'd32768, 16'd32768);
    queue_dry(16'sd1000, 1'b1);
    queue_dry(16'sd1000, 1'b0);
    queue_dry(16'sd1000, 1'b0);
    wait_drained();

    // Every register at its top value.
    set_idling(IDLE_SENDER);
    load_setting(2'd3, 14'h3fff, 14'h3fff, 14'h3fff, 16'hffff, 16'hffff, 16'hffff);
    queue_track(30, 1'b0);
    wait_drained();

    // Every register at its bottom value.
    set_idling(IDLE_RECEIVER);
    load_setting(2'd0, 14'd0, 14'd0, 14'd0, 16'd0, 16'd0, 16'd0);
    queue_track(30, 1'b0);
    wait_drained();

    // Loudest possible mix: all taps one sample back at the largest gain.
    set_idling(IDLE_BOTH);
    load_setting(2'd3, 14'd1, 14'd1, 14'd1, 16'hffff, 16'hffff, 16'hffff);
    queue_track(25, 1'b1);
    wait_drained();

    // Random settings; history carries over between phases unless a restart cuts it.
    for (int phase = 0; phase < 8; phase++) begin
      set_idling(phase % 4);
      taps = ($urandom_range(7) < 5) ? 2'd3 : 2'($urandom_range(2));
      load_setting(taps, random_delay(), random_delay(), random_delay(),
                   random_gain(), random_gain(), random_gain());
      queue_track(160, $urandom_range(2) == 0);
      wait_drained();
    end

    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
